>>> hdl/cuckoo_hash_lookup_assert.svh
// Assertion macros for the cuckoo hash lookup block.
`ifndef CUCKOO_HASH_LOOKUP_ASSERT_SVH
`define CUCKOO_HASH_LOOKUP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("cuckoo_hash_lookup: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("cuckoo_hash_lookup: next-cycle check failed");

`endif

>>> hdl/chl_pkg.sv
package chl_pkg;

  // Fixed geometry
  localparam int unsigned WAYS   = 3;
  localparam int unsigned SIZE_W = 13;          // slots-per-section register width
  localparam int unsigned SUM_W  = SIZE_W + 2;  // holds pos + way * size
  localparam int unsigned STU_W  = 5;           // stash_used register width

  localparam logic [1:0] LAST_WAY = 2'(WAYS - 1);

  // Opcodes
  localparam logic [1:0] OP_LOOKUP      = 2'd0;
  localparam logic [1:0] OP_WRITE_TABLE = 2'd1;
  localparam logic [1:0] OP_WRITE_STASH = 2'd2;

  // Register indexes
  localparam logic REG_SECT_SIZE  = 1'b0;
  localparam logic REG_STASH_USED = 1'b1;

  // Match source code for the stash
  localparam logic [1:0] SRC_STASH = 2'd3;

  // Mixer constants
  localparam logic [63:0] SEED_WAY1 = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SEED_WAY2 = 64'hd1b54a32d192ed03;
  localparam logic [63:0] MIX_MUL1  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL2  = 64'h94d049bb133111eb;
  localparam int unsigned MIX_SH0   = 30;
  localparam int unsigned MIX_SH1   = 27;
  localparam int unsigned MIX_SH2   = 31;

  // Top-level sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HSTART,
    ST_HASH,
    ST_TRD,
    ST_TCMP,
    ST_SRD,
    ST_SCMP,
    ST_DONE
  } chl_state_e;

  // Hash unit step sequencer states
  typedef enum logic [3:0] {
    HS_IDLE,
    HS_M1_LL,
    HS_M1_HL,
    HS_M1_LH,
    HS_M1_FIN,
    HS_M2_LL,
    HS_M2_HL,
    HS_M2_LH,
    HS_M2_FIN,
    HS_R_LO,
    HS_R_HI,
    HS_R_FIN
  } hstep_e;

  // Hash unit request and response
  typedef struct packed {
    logic       start;
    logic [1:0] way;
  } chl_hreq_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] pos;
  } chl_hrsp_t;

  // Per-section seed
  function automatic logic [63:0] hash_seed(input logic [1:0] way);
    logic [63:0] s;
    case (way)
      2'd0:    s = '0;
      2'd1:    s = SEED_WAY1;
      2'd2:    s = SEED_WAY2;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

>>> hdl/chl_ram.sv
module chl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/chl_hash_unit.sv
module chl_hash_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  chl_pkg::chl_hreq_t        req_i,
  input  logic [63:0]               key_i,
  input  logic [chl_pkg::SIZE_W-1:0] size_i,
  output chl_pkg::chl_hrsp_t        rsp_o
);

  import chl_pkg::*;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADDHI,
    ACC_LOADHI
  } acc_op_e;

  hstep_e step_q, step_d;
  logic [63:0] v_q, acc_q, prod_q;
  logic        done_q;
  logic [SIZE_W-1:0] pos_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  acc_op_e     acc_op;
  logic        v_load;
  logic        pos_load;
  logic [63:0] seed_x, t_sum, xs_out, mid;

  // Step sequencer: next step
  always_comb begin
    step_d = step_q;
    case (step_q)
      HS_IDLE:   if (req_i.start) step_d = HS_M1_LL;
      HS_M1_LL:  step_d = HS_M1_HL;
      HS_M1_HL:  step_d = HS_M1_LH;
      HS_M1_LH:  step_d = HS_M1_FIN;
      HS_M1_FIN: step_d = HS_M2_LL;
      HS_M2_LL:  step_d = HS_M2_HL;
      HS_M2_HL:  step_d = HS_M2_LH;
      HS_M2_LH:  step_d = HS_M2_FIN;
      HS_M2_FIN: step_d = HS_R_LO;
      HS_R_LO:   step_d = HS_R_HI;
      HS_R_HI:   step_d = HS_R_FIN;
      HS_R_FIN:  step_d = HS_IDLE;
      default:   step_d = HS_IDLE;
    endcase
  end

  // Low 64 bits of acc + (prod << 32)
  assign t_sum  = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};
  assign seed_x = key_i ^ hash_seed(req_i.way);
  assign mid    = prod_q + acc_q;

  // Step sequencer: operand selection and xor-shift
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    acc_op   = ACC_HOLD;
    v_load   = 1'b0;
    pos_load = 1'b0;
    xs_out   = seed_x ^ (seed_x >> MIX_SH0);
    case (step_q)
      HS_IDLE: begin
        v_load = req_i.start;
      end
      HS_M1_LL: begin
        mul_a = v_q[31:0];
        mul_b = MIX_MUL1[31:0];
      end
      HS_M1_HL: begin
        mul_a  = v_q[63:32];
        mul_b  = MIX_MUL1[31:0];
        acc_op = ACC_LOAD;
      end
      HS_M1_LH: begin
        mul_a  = v_q[31:0];
        mul_b  = MIX_MUL1[63:32];
        acc_op = ACC_ADDHI;
      end
      HS_M1_FIN: begin
        xs_out = t_sum ^ (t_sum >> MIX_SH1);
        v_load = 1'b1;
      end
      HS_M2_LL: begin
        mul_a = v_q[31:0];
        mul_b = MIX_MUL2[31:0];
      end
      HS_M2_HL: begin
        mul_a  = v_q[63:32];
        mul_b  = MIX_MUL2[31:0];
        acc_op = ACC_LOAD;
      end
      HS_M2_LH: begin
        mul_a  = v_q[31:0];
        mul_b  = MIX_MUL2[63:32];
        acc_op = ACC_ADDHI;
      end
      HS_M2_FIN: begin
        xs_out = t_sum ^ (t_sum >> MIX_SH2);
        v_load = 1'b1;
      end
      HS_R_LO: begin
        mul_a = v_q[31:0];
        mul_b = 32'(size_i);
      end
      HS_R_HI: begin
        mul_a  = v_q[63:32];
        mul_b  = 32'(size_i);
        acc_op = ACC_LOADHI;
      end
      HS_R_FIN: begin
        pos_load = 1'b1;
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // Shared 32x32 multiplier
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= HS_IDLE;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= pos_load;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    case (acc_op)
      ACC_LOAD:   acc_q <= prod_q;
      ACC_ADDHI:  acc_q <= t_sum;
      ACC_LOADHI: acc_q <= {32'h0, prod_q[63:32]};
      default:    acc_q <= acc_q;
    endcase
    if (v_load) begin
      v_q <= xs_out;
    end
    // high word of h * size is below size
    if (pos_load) begin
      pos_q <= mid[32 +: SIZE_W];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.pos  = pos_q;

endmodule

>>> hdl/cuckoo_hash_lookup.sv
// Lookup: no new word is accepted until the search ends and its last result word is loaded;
// its results come out through a one-word output register while the search goes on.
// Each section is hashed step by step on the shared 32x32 multiplier (eight products per hash).
// Table and stash writes, and unknown opcodes, are taken in idle and leave the block idle.
// After reset all 3 * SECTION_DEPTH table slots (12288 by default) are zeroed one slot a
// cycle; no word is accepted meanwhile, configuration writes are.
`include "cuckoo_hash_lookup_assert.svh"

module cuckoo_hash_lookup #(
  parameter int unsigned SECTION_DEPTH = 4096,
  parameter int unsigned STASH_DEPTH   = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [chl_pkg::SIZE_W-1:0] cfg_data_i,
  // input words
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 opcode_i,
  input  logic [63:0]                full_key_i,
  input  logic [13:0]                slot_index_i,
  input  logic [31:0]                slot_key_i,
  input  logic [31:0]                slot_value_i,
  // result words
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [31:0]                match_value_o,
  output logic                       hit_o,
  output logic [1:0]                 match_source_o,
  output logic                       last_o
);

  import chl_pkg::*;

  localparam int unsigned TABLE_SLOTS = WAYS * SECTION_DEPTH;
  localparam int unsigned TA_W = $clog2(TABLE_SLOTS);
  localparam int unsigned ST_W = (STASH_DEPTH > 1) ? $clog2(STASH_DEPTH) : 1;
  localparam int unsigned SC_W = $clog2(STASH_DEPTH + 1);

  chl_state_e state_q, state_d;

  logic [SIZE_W-1:0] sect_size_q;
  logic [STU_W-1:0]  stash_used_q;
  logic [SIZE_W-1:0] s_eff;
  logic [SC_W-1:0]   cnt_eff;

  logic [TA_W-1:0]  clr_q;
  logic [TA_W-1:0]  addr_q;
  logic [63:0]      key_q;
  logic [1:0]       way_q;
  logic [SUM_W-1:0] base_q;
  logic [SC_W-1:0]  sidx_q;

  logic        pend_v_q;
  logic [31:0] pend_val_q;
  logic [1:0]  pend_src_q;

  logic        out_valid_q;
  logic [31:0] out_val_q;
  logic        out_hit_q;
  logic [1:0]  out_src_q;
  logic        out_last_q;

  logic            in_accept;
  logic            out_free;
  logic            tbl_we;
  logic [TA_W-1:0] tbl_waddr;
  logic [63:0]     tbl_wdata;
  logic [63:0]     tbl_rdata;
  logic            stash_we;
  logic [95:0]     stash_rdata;
  logic            tbl_match, stash_match;
  logic            cur_match;
  logic [31:0]     cur_val;
  logic [1:0]      cur_src;
  logic            adv;
  logic            push_out;
  logic            sidx_last;
  chl_hreq_t       hu_req;
  chl_hrsp_t       hu_rsp;

  // Effective sizes after clamping
  always_comb begin
    if (sect_size_q == '0) begin
      s_eff = SIZE_W'(1);
    end else if (32'(sect_size_q) > SECTION_DEPTH) begin
      s_eff = SIZE_W'(SECTION_DEPTH);
    end else begin
      s_eff = sect_size_q;
    end
    if (32'(stash_used_q) > STASH_DEPTH) begin
      cnt_eff = SC_W'(STASH_DEPTH);
    end else begin
      cnt_eff = SC_W'(stash_used_q);
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign sidx_last  = ((sidx_q + 1'b1) == cnt_eff);

  // Entry compares
  assign tbl_match   = (tbl_rdata[31:0] != '0) && (tbl_rdata[63:32] == key_q[63:32]);
  assign stash_match = (stash_rdata[95:32] == key_q);

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == TA_W'(TABLE_SLOTS - 1)) state_d = ST_IDLE;
      ST_IDLE:   if (in_accept && opcode_i == OP_LOOKUP) state_d = ST_HSTART;
      ST_HSTART: state_d = ST_HASH;
      ST_HASH:   if (hu_rsp.done) state_d = ST_TRD;
      ST_TRD:    state_d = ST_TCMP;
      ST_TCMP: begin
        if (adv) begin
          if (way_q != LAST_WAY) begin
            state_d = ST_HSTART;
          end else if (cnt_eff == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SRD;
          end
        end
      end
      ST_SRD:    state_d = ST_SCMP;
      ST_SCMP:   if (adv) state_d = sidx_last ? ST_DONE : ST_SRD;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    tbl_we       = 1'b0;
    tbl_waddr    = TA_W'(slot_index_i);
    tbl_wdata    = {slot_key_i, slot_value_i};
    stash_we     = 1'b0;
    hu_req.start = 1'b0;
    hu_req.way   = way_q;
    cur_match    = 1'b0;
    cur_val      = tbl_rdata[31:0];
    cur_src      = way_q;
    case (state_q)
      ST_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_waddr = clr_q;
        tbl_wdata = '0;
      end
      ST_IDLE: begin
        tbl_we   = in_accept && (opcode_i == OP_WRITE_TABLE) &&
                   (32'(slot_index_i) < TABLE_SLOTS);
        stash_we = in_accept && (opcode_i == OP_WRITE_STASH) &&
                   (32'(slot_index_i) < STASH_DEPTH);
      end
      ST_HSTART: begin
        hu_req.start = 1'b1;
      end
      ST_TCMP: begin
        cur_match = tbl_match;
      end
      ST_SCMP: begin
        cur_match = stash_match;
        cur_val   = stash_rdata[31:0];
        cur_src   = SRC_STASH;
      end
      default: begin
        cur_match = 1'b0;
      end
    endcase
  end

  // A new match pushes the held one out; it waits while the output register is busy
  assign adv      = ((state_q == ST_TCMP) || (state_q == ST_SCMP)) &&
                    !(cur_match && pend_v_q && !out_free);
  assign push_out = (adv && cur_match && pend_v_q) || ((state_q == ST_DONE) && out_free);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      way_q        <= '0;
      base_q       <= '0;
      sidx_q       <= '0;
      pend_v_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      sect_size_q  <= SIZE_W'(4096);
      stash_used_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      // section and stash walk
      if (state_q == ST_IDLE) begin
        way_q  <= '0;
        base_q <= '0;
      end else if (state_q == ST_TCMP && adv && way_q != LAST_WAY) begin
        way_q  <= way_q + 1'b1;
        base_q <= base_q + SUM_W'(s_eff);
      end
      if (state_q == ST_TCMP) begin
        sidx_q <= '0;
      end else if (state_q == ST_SCMP && adv) begin
        sidx_q <= sidx_q + 1'b1;
      end
      // held match
      if (adv && cur_match) begin
        pend_v_q <= 1'b1;
      end else if (state_q == ST_DONE && out_free) begin
        pend_v_q <= 1'b0;
      end
      // output register
      if (push_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // configuration
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SECT_SIZE:  sect_size_q  <= cfg_data_i;
          REG_STASH_USED: stash_used_q <= cfg_data_i[STU_W-1:0];
          default:        stash_used_q <= stash_used_q;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      key_q <= full_key_i;
    end
    if (state_q == ST_HASH && hu_rsp.done) begin
      addr_q <= TA_W'({2'b00, hu_rsp.pos} + base_q);
    end
    if (adv && cur_match) begin
      pend_val_q <= cur_val;
      pend_src_q <= cur_src;
    end
    if (push_out) begin
      if (state_q == ST_DONE) begin
        out_val_q  <= pend_v_q ? pend_val_q : '0;
        out_hit_q  <= pend_v_q;
        out_src_q  <= pend_v_q ? pend_src_q : '0;
        out_last_q <= 1'b1;
      end else begin
        out_val_q  <= pend_val_q;
        out_hit_q  <= 1'b1;
        out_src_q  <= pend_src_q;
        out_last_q <= 1'b0;
      end
    end
  end

  chl_hash_unit u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (hu_req),
    .key_i  (key_q),
    .size_i (s_eff),
    .rsp_o  (hu_rsp)
  );

  // Table: key part in the upper half, value in the lower half
  chl_ram #(
    .WIDTH (64),
    .DEPTH (TABLE_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (addr_q),
    .rdata_o (tbl_rdata)
  );

  // Stash: full key over value
  chl_ram #(
    .WIDTH (96),
    .DEPTH (STASH_DEPTH)
  ) u_stash (
    .clk_i   (clk_i),
    .we_i    (stash_we),
    .waddr_i (ST_W'(slot_index_i)),
    .wdata_i ({full_key_i, slot_value_i}),
    .raddr_i (sidx_q[ST_W-1:0]),
    .rdata_o (stash_rdata)
  );

  assign out_valid_o    = out_valid_q;
  assign match_value_o  = out_val_q;
  assign hit_o          = out_hit_q;
  assign match_source_o = out_src_q;
  assign last_o         = out_last_q;

  // Checks
  `CHL_ASSERT_IMP(a_hash_done_in_hash, clk_i, rst_ni, hu_rsp.done, state_q == ST_HASH)
  `CHL_ASSERT_IMP(a_tbl_we_not_in_lookup, clk_i, rst_ni, tbl_we,
                  state_q == ST_CLEAR || state_q == ST_IDLE)
  `CHL_ASSERT_IMP(a_miss_word_clean, clk_i, rst_ni, out_valid_q && !out_hit_q,
                  out_val_q == '0 && out_src_q == '0 && out_last_q)
  `CHL_ASSERT_IMP(a_idle_no_pending, clk_i, rst_ni, state_q == ST_IDLE, !pend_v_q)
  `CHL_ASSERT_NXT(a_push_leaves_valid, clk_i, rst_ni, push_out, out_valid_q)

endmodule
